// ===== hdl/tneq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the timed note event queue.
// No dependencies.
package tneq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned FRAME_BITS_DEF  = 48;

  localparam int unsigned RATE_W    = 18;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned FRAMES_W  = 16;
  localparam int unsigned DUE_W     = 48;
  localparam int unsigned PAYLOAD_W = 24;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = RATE_W'(44100);

  // delay_ms * sample_rate, then divide by 1000 as (x >> 3) / 125
  localparam int unsigned PROD_W      = DELAY_W + RATE_W;
  localparam int unsigned DIV_PRE     = 3;
  localparam int unsigned SCALED_W    = PROD_W - DIV_PRE;
  localparam int unsigned RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;  // ceil(2^38 / 125)
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned MUL2_W      = SCALED_W + RECIP_W;
  localparam int unsigned QUOT_W      = MUL2_W - RECIP_SHIFT;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  localparam logic REG_SAMPLE_RATE = 1'b0;

  typedef enum logic [2:0] {
    KIND_NOTE_ON    = 3'd0,
    KIND_NOTE_OFF   = 3'd1,
    KIND_TICK_DONE  = 3'd2,
    KIND_SCHEDULED  = 3'd3,
    KIND_DROPPED    = 3'd4
  } kind_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } tneq_ctrl_t;

endpackage

// ===== hdl/timed_note_event_queue.sv =====
`timescale 1ns / 1ps
// Timed note event queue: top level with command port, APB register and chain.
// Depends on tneq_pkg, tneq_cell, tneq_scale.
//
// Usage:
//   Commands enter when start is high and busy is low. action selects note on,
//   note off (both schedule an event delay_ms after the current frame) or an
//   audio tick; action 3 is taken and ignored.
//   Each result appears for one cycle with result_valid high; last marks the
//   final result of a command. The receiver cannot stall the block.
//   Schedule: the result (kind scheduled or dropped) follows states MUL, DIV and
//   INS, which cover the two registered multiplies and the add of the due-frame
//   unit. Tick: busy in state DRAIN; one result per cycle, one per due event
//   popped from the head of the chain, then tick done.
//   A new command can start in the cycle that shows the final result.
//   Events live in a chain of QUEUE_DEPTH cells kept sorted by due frame; an
//   insert shifts the entries not below the new due frame one cell right.
//   sample_rate sits at byte address 0 of the APB port; write it only idle.
//   Reset empties the queue, zeroes the frame counter and sets 44100 Hz.
module timed_note_event_queue import tneq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned FRAME_BITS  = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [7:0]           patch_number,
  input  logic [6:0]           note_pitch,
  input  logic [7:0]           note_velocity,
  input  logic [DELAY_W-1:0]   delay_ms,
  input  logic [FRAMES_W-1:0]  num_frames,
  output logic                 result_valid,
  output logic [2:0]           kind,
  output logic [7:0]           out_patch,
  output logic [6:0]           out_pitch,
  output logic [7:0]           out_velocity,
  output logic [DUE_W-1:0]     due_frame,
  output logic                 last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_INS,
    ST_DRAIN
  } state_t;

  state_t                state;
  logic [RATE_W-1:0]     sample_rate;
  logic [FRAME_BITS-1:0] current_frame;
  logic [CNT_W-1:0]      count;
  logic [PAYLOAD_W-1:0]  new_payload;
  logic [FRAMES_W-1:0]   frames;
  logic [FRAME_BITS-1:0] new_due;
  logic [FRAME_BITS-1:0] frame_next;
  logic [FRAME_BITS-1:0] cell_due     [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0]  cell_payload [QUEUE_DEPTH];
  logic                  cell_ge      [QUEUE_DEPTH];
  logic                  full;
  logic                  head_due;
  tneq_ctrl_t            ctrl;

  function automatic logic [DUE_W-1:0] to_due(input logic [FRAME_BITS-1:0] f);
    logic [63:0] wide;
    wide = 64'(f);
    return wide[DUE_W-1:0];
  endfunction

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? 32'(sample_rate) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_RATE) begin
      sample_rate <= pwdata[RATE_W-1:0];
    end
  end

  tneq_scale #(
    .FRAME_BITS (FRAME_BITS)
  ) u_scale (
    .clk           (clk),
    .delay_ms      (delay_ms),
    .sample_rate   (sample_rate),
    .current_frame (current_frame),
    .due           (new_due)
  );

  assign busy       = (state != ST_IDLE);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_due   = (count != '0) && (cell_due[0] < current_frame);
  assign frame_next = current_frame + FRAME_BITS'(frames);
  assign ctrl.insert = (state == ST_INS) && !full;
  assign ctrl.pop    = (state == ST_DRAIN) && head_due;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  l_ge;
    logic [FRAME_BITS-1:0] l_due;
    logic [PAYLOAD_W-1:0]  l_payload;
    logic [FRAME_BITS-1:0] r_due;
    logic [PAYLOAD_W-1:0]  r_payload;

    if (i == 0) begin : g_first
      assign l_ge      = 1'b0;
      assign l_due     = new_due;
      assign l_payload = new_payload;
    end else begin : g_inner
      assign l_ge      = cell_ge[i-1];
      assign l_due     = cell_due[i-1];
      assign l_payload = cell_payload[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_due     = cell_due[i];
      assign r_payload = cell_payload[i];
    end else begin : g_body
      assign r_due     = cell_due[i+1];
      assign r_payload = cell_payload[i+1];
    end

    tneq_cell #(
      .INDEX      (i),
      .FRAME_BITS (FRAME_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .count         (count),
      .new_due       (new_due),
      .new_payload   (new_payload),
      .left_ge       (l_ge),
      .left_due      (l_due),
      .left_payload  (l_payload),
      .right_due     (r_due),
      .right_payload (r_payload),
      .due           (cell_due[i]),
      .payload       (cell_payload[i]),
      .ge            (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_frame <= '0;
      count         <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            frames <= num_frames;
            if (action == ACT_NOTE_ON) begin
              new_payload <= {note_velocity, patch_number, note_pitch, 1'b0};
              state       <= ST_MUL;
            end else if (action == ACT_NOTE_OFF) begin
              new_payload <= {8'd0, patch_number, note_pitch, 1'b1};
              state       <= ST_MUL;
            end else if (action == ACT_TICK) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: state <= ST_INS;
        ST_INS: begin
          result_valid <= 1'b1;
          kind         <= full ? KIND_DROPPED : KIND_SCHEDULED;
          out_patch    <= new_payload[15:8];
          out_pitch    <= new_payload[7:1];
          out_velocity <= new_payload[23:16];
          due_frame    <= to_due(new_due);
          last         <= 1'b1;
          if (!full) begin
            count <= count + CNT_W'(1);
          end
          state <= ST_IDLE;
        end
        ST_DRAIN: begin
          result_valid <= 1'b1;
          if (head_due) begin
            kind         <= cell_payload[0][0] ? KIND_NOTE_OFF : KIND_NOTE_ON;
            out_patch    <= cell_payload[0][15:8];
            out_pitch    <= cell_payload[0][7:1];
            out_velocity <= cell_payload[0][23:16];
            due_frame    <= to_due(cell_due[0]);
            last         <= 1'b0;
            count        <= count - CNT_W'(1);
          end else begin
            kind          <= KIND_TICK_DONE;
            out_patch     <= '0;
            out_pitch     <= '0;
            out_velocity  <= '0;
            due_frame     <= to_due(frame_next);
            last          <= 1'b1;
            current_frame <= frame_next;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tneq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted event chain: holds a due frame and packed payload.
// Depends on tneq_pkg.
module tneq_cell import tneq_pkg::*; #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                  clk,
  input  tneq_ctrl_t            ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [FRAME_BITS-1:0] new_due,
  input  logic [PAYLOAD_W-1:0]  new_payload,
  input  logic                  left_ge,
  input  logic [FRAME_BITS-1:0] left_due,
  input  logic [PAYLOAD_W-1:0]  left_payload,
  input  logic [FRAME_BITS-1:0] right_due,
  input  logic [PAYLOAD_W-1:0]  right_payload,
  output logic [FRAME_BITS-1:0] due,
  output logic [PAYLOAD_W-1:0]  payload,
  output logic                  ge
);

  // empty slot or stored due not below the new one
  assign ge = (CNT_W'(INDEX) >= count) || (due >= new_due);

  always_ff @(posedge clk) begin
    if (ctrl.insert && ge) begin
      if (left_ge) begin
        due     <= left_due;
        payload <= left_payload;
      end else begin
        due     <= new_due;
        payload <= new_payload;
      end
    end else if (ctrl.pop) begin
      due     <= right_due;
      payload <= right_payload;
    end
  end

endmodule

// ===== hdl/tneq_scale.sv =====
`timescale 1ns / 1ps
// Due frame pipeline: current_frame + floor(delay_ms * sample_rate / 1000).
// Three register stages, free running. Depends on tneq_pkg.
module tneq_scale import tneq_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic [DELAY_W-1:0]    delay_ms,
  input  logic [RATE_W-1:0]     sample_rate,
  input  logic [FRAME_BITS-1:0] current_frame,
  output logic [FRAME_BITS-1:0] due
);

  logic [PROD_W-1:0] prod;
  logic [MUL2_W-1:0] prod2;

  always_ff @(posedge clk) begin
    prod  <= PROD_W'(delay_ms) * PROD_W'(sample_rate);
    prod2 <= MUL2_W'(prod[PROD_W-1:DIV_PRE]) * MUL2_W'(RECIP_125);
    due   <= current_frame + FRAME_BITS'(prod2[MUL2_W-1:RECIP_SHIFT]);
  end

endmodule

// ===== tb/sv/timed_note_event_queue_tb.sv =====
`timescale 1ns / 1ps
// Testbench for timed_note_event_queue: directed and random note/tick commands,
// checked against a built-in sorted-queue predictor; sample_rate set over APB.
// Depends on tneq_pkg and the timed_note_event_queue RTL.
module timed_note_event_queue_tb;
  import tneq_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam logic [2:0] SAMPLE_RATE_ADDR = 3'(4 * REG_SAMPLE_RATE);
  localparam int unsigned SLOTS = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]          action;
    logic [7:0]          patch;
    logic [6:0]          pitch;
    logic [7:0]          velocity;
    logic [DELAY_W-1:0]  delay;
    logic [FRAMES_W-1:0] frames;
  } command_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       patch;
    logic [6:0]       pitch;
    logic [7:0]       velocity;
    logic [DUE_W-1:0] due;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic             is_off;
    logic [7:0]       patch;
    logic [6:0]       pitch;
    logic [7:0]       velocity;
  } note_entry_t;

  class event_queue_scoreboard;
    logic [RATE_W-1:0] rate;
    logic [DUE_W-1:0]  frame_now;
    note_entry_t       held_notes[$];
    result_t           awaited[$];
    int unsigned       mismatches;

    function new();
      rate = SAMPLE_RATE_RESET;
      frame_now = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void record_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR at %0t ns: %s", $realtime, msg);
      end
    endfunction

    function void push_result(kind_t k, note_entry_t n, logic fin);
      result_t r;
      r.kind = k;
      r.patch = n.patch;
      r.pitch = n.pitch;
      r.velocity = n.velocity;
      r.due = n.due;
      r.last = fin;
      awaited.push_back(r);
    endfunction

    // note an accepted transaction and queue the results it must cause
    function void take_command(command_t c);
      note_entry_t n;
      logic [63:0] span;
      int pos;
      if (c.action == ACT_NOTE_ON || c.action == ACT_NOTE_OFF) begin
        n.is_off = (c.action == ACT_NOTE_OFF);
        n.patch = c.patch;
        n.pitch = c.pitch;
        n.velocity = n.is_off ? 8'd0 : c.velocity;
        span = (64'(c.delay) * 64'(rate)) / 64'd1000;
        n.due = DUE_W'(64'(frame_now) + span);
        if (held_notes.size() >= SLOTS) begin
          push_result(KIND_DROPPED, n, 1'b1);
        end else begin
          pos = 0;
          while (pos < held_notes.size() && held_notes[pos].due < n.due) pos++;
          held_notes.insert(pos, n);
          push_result(KIND_SCHEDULED, n, 1'b1);
        end
      end else if (c.action == ACT_TICK) begin
        while (held_notes.size() > 0 && held_notes[0].due < frame_now) begin
          n = held_notes.pop_front();
          push_result(n.is_off ? KIND_NOTE_OFF : KIND_NOTE_ON, n, 1'b0);
        end
        frame_now = frame_now + DUE_W'(c.frames);
        n = '0;
        n.due = frame_now;
        push_result(KIND_TICK_DONE, n, 1'b1);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        record_mismatch($sformatf({"unexpected result kind=%0d patch=%0d pitch=%0d",
          " vel=%0d due=%0d last=%0d"},
          got.kind, got.patch, got.pitch, got.velocity, got.due, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.patch !== want.patch || got.pitch !== want.pitch ||
          got.velocity !== want.velocity || got.due !== want.due || got.last !== want.last) begin
        record_mismatch($sformatf({"exp kind=%0d patch=%0d pitch=%0d vel=%0d due=%0d last=%0d",
          " | got kind=%0d patch=%0d pitch=%0d vel=%0d due=%0d last=%0d"},
          want.kind, want.patch, want.pitch, want.velocity, want.due, want.last,
          got.kind, got.patch, got.pitch, got.velocity, got.due, got.last));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          action = '0;
  logic [7:0]          patch_number = '0;
  logic [6:0]          note_pitch = '0;
  logic [7:0]          note_velocity = '0;
  logic [DELAY_W-1:0]  delay_ms = '0;
  logic [FRAMES_W-1:0] num_frames = '0;
  logic                result_valid;
  logic [2:0]          kind;
  logic [7:0]          out_patch;
  logic [6:0]          out_pitch;
  logic [7:0]          out_velocity;
  logic [DUE_W-1:0]    due_frame;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  event_queue_scoreboard sb = new();

  timed_note_event_queue dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : sample_results
    result_t seen;
    if (!rst && result_valid) begin
      seen.kind = kind;
      seen.patch = out_patch;
      seen.pitch = out_pitch;
      seen.velocity = out_velocity;
      seen.due = due_frame;
      seen.last = last;
      sb.check_result(seen);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // start stays high across back-to-back transactions
  task automatic send_command(input command_t c, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action <= c.action;
    patch_number <= c.patch;
    note_pitch <= c.pitch;
    note_velocity <= c.velocity;
    delay_ms <= c.delay;
    num_frames <= c.frames;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_command(c);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_sample_rate(input logic [RATE_W-1:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SAMPLE_RATE_ADDR;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.rate = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[RATE_W-1:0] !== value) begin
      sb.record_mismatch($sformatf("sample_rate readback exp=%0d got=%0d", value,
        prdata[RATE_W-1:0]));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic command_t random_command(input logic [RATE_W-1:0] rate_now);
    command_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) c.action = ACT_NOTE_ON;
    else if (pick < 70) c.action = ACT_NOTE_OFF;
    else if (pick < 96) c.action = ACT_TICK;
    else c.action = ACT_IGNORED;
    c.patch = 8'($urandom);
    c.pitch = 7'($urandom);
    c.velocity = 8'($urandom);
    // long delays only at low rates, so the queue still drains
    if (rate_now <= RATE_W'(8000) && $urandom_range(0, 7) == 0) c.delay = 16'($urandom);
    else if ($urandom_range(0, 4) == 0) c.delay = '0;
    else c.delay = 16'($urandom_range(1, 100));
    if ($urandom_range(0, 7) == 0) c.frames = 16'($urandom);
    else if ($urandom_range(0, 9) == 0) c.frames = '0;
    else c.frames = 16'($urandom_range(1000, 20000));
    return c;
  endfunction

  initial begin : stimulus
    command_t c;
    logic [RATE_W-1:0] rates[6];
    bit burst;
    int unsigned sent;
    rates[0] = RATE_W'(8000);
    rates[1] = RATE_W'(192000);
    rates[2] = '0;
    rates[3] = '1;
    rates[4] = RATE_W'($urandom_range(8000, 192000));
    rates[5] = SAMPLE_RATE_RESET;
    burst = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, equal due frames, ignored code, full queue, 16-event drain
    send_command(command_t'{ACT_NOTE_ON, 8'hFF, 7'h7F, 8'hFF, 16'd0, 16'hFFFF}, 0);
    send_command(command_t'{ACT_NOTE_OFF, 8'h00, 7'h00, 8'hFF, 16'd0, 16'h0000},
      $urandom_range(0, 5));
    send_command(command_t'{ACT_TICK, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF, 16'd0}, 0);
    send_command(command_t'{ACT_TICK, 8'h00, 7'h00, 8'h00, 16'd0, 16'hFFFF},
      $urandom_range(0, 5));
    send_command(command_t'{ACT_IGNORED, 8'h5A, 7'h2B, 8'hC3, 16'h1234, 16'h4321}, 0);
    send_command(command_t'{ACT_TICK, 8'h00, 7'h00, 8'h00, 16'd0, 16'd0}, 0);
    for (int i = 0; i < SLOTS; i++) begin
      c = random_command(sb.rate);
      c.action = i[0] ? ACT_NOTE_OFF : ACT_NOTE_ON;
      c.delay = '0;
      send_command(c, (i < 8) ? 0 : $urandom_range(0, 5));
    end
    send_command(command_t'{ACT_NOTE_ON, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF, 16'd0}, 0);
    send_command(command_t'{ACT_TICK, 8'h00, 7'h00, 8'h00, 16'd0, 16'd1}, 0);
    send_command(command_t'{ACT_TICK, 8'h00, 7'h00, 8'h00, 16'd0, 16'd0}, 0);

    foreach (rates[p]) begin
      write_sample_rate(rates[p]);
      sent = 0;
      while (sent < 32) begin
        c = random_command(sb.rate);
        if ($urandom_range(0, 9) == 0) burst = !burst;
        if ($urandom_range(0, 29) == 0) wait_idle();
        send_command(c, burst ? 0 : $urandom_range(0, 5));
        if (c.action != ACT_IGNORED) sent++;
      end
    end

    wait_idle();
    repeat (12) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== timed_note_event_queue.f =====
hdl/tneq_pkg.sv
hdl/tneq_cell.sv
hdl/tneq_scale.sv
hdl/timed_note_event_queue.sv
tb/sv/timed_note_event_queue_tb.sv
